// File: rtl/bsh_pkg.sv
// Shared constants, codes and types of the bucketed sorted hash lookup.
package bsh_pkg;

  localparam int MAX_TABLE_BITS_DEF = 12;
  localparam int ENTRIES_DEF        = 65536;

  localparam int START_W = 17;
  localparam int POS_W   = 16;
  localparam int SLOT_W  = 16;
  localparam int KEY_W   = 64;
  localparam int TB_W    = 4;

  localparam logic [TB_W-1:0] TABLE_BITS_RST = 4'd12;

  localparam logic [1:0] OP_WR_START = 2'd0;
  localparam logic [1:0] OP_WR_HASH  = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_END,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic query;
    logic empty;
    logic hash_eq;
    logic hash_gt;
    logic last;
  } fsm_stat_t;

  typedef struct packed {
    logic busy;
    logic ld_key;
    logic ld_start;
    logic ld_end;
    logic scan_init;
    logic scan_adv;
    logic done;
    logic hit;
  } fsm_ctrl_t;

endpackage

// File: rtl/bucketed_sorted_hash_lookup.sv
// Top level of the bucketed sorted hash lookup: tables, datapath and sequencer.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ---------------------------
//   input    in_opcode, in_slot, in_word             start high while busy low
//   result   out_found, out_position,                out_valid high one cycle
//            out_bucket_size
//   config   cfg_wdata (table_bits)                  cfg_we high at the edge
//
// A load item (write bucket start or entry hash) does not raise busy; opcode 3
// is dropped, also without raising busy. A query reads the start table twice
// through its single read port, then reads and compares one entry per cycle
// from the entry RAM until a hit, a greater hash or the bucket end; an empty
// bucket reads no entry. The result strobes on the cycle after the query ends.
// Reset (synchronous, active low) returns the sequencer to idle and table_bits
// to 12; both tables hold garbage until loaded. The receiver cannot stall: a
// result is shown for exactly one cycle, and busy alone holds off new items.
module bucketed_sorted_hash_lookup
  import bsh_pkg::*;
#(
  parameter int MAX_TABLE_BITS = MAX_TABLE_BITS_DEF,
  parameter int ENTRIES        = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [KEY_W-1:0]   in_word,
  input  logic               cfg_we,
  input  logic [TB_W-1:0]    cfg_wdata,
  output logic               out_valid,
  output logic               out_found,
  output logic [POS_W-1:0]   out_position,
  output logic [START_W-1:0] out_bucket_size
);

  localparam int STARTS_DEPTH = (1 << MAX_TABLE_BITS) + 1;
  localparam int SADDR_W      = $clog2(STARTS_DEPTH);
  localparam int EIDX_W       = $clog2(ENTRIES);
  localparam int CNT_W        = (EIDX_W + 1 > START_W) ? EIDX_W + 1 : START_W;
  localparam int SH_W         = $clog2(MAX_TABLE_BITS + 1);

  fsm_stat_t stat;
  fsm_ctrl_t ctrl;

  logic accept;
  assign accept = start && !ctrl.busy;
  assign busy   = ctrl.busy;

  // Configuration register; the user must write it only while idle (not enforced).
  logic [TB_W-1:0] table_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_bits_r <= TABLE_BITS_RST;
    end else if (cfg_we) begin
      table_bits_r <= cfg_wdata;
    end
  end

  // Bucket select: saturate table_bits, then take that many top key bits by
  // shifting the top MAX_TABLE_BITS bits down. Zero table bits shifts out all.
  logic [SH_W-1:0]           tb_sat;
  logic [SH_W-1:0]           shamt;
  logic [MAX_TABLE_BITS-1:0] bucket_in;

  always_comb begin
    if (int'(table_bits_r) > MAX_TABLE_BITS) begin
      tb_sat = SH_W'(MAX_TABLE_BITS);
    end else begin
      tb_sat = SH_W'(table_bits_r);
    end
    shamt     = SH_W'(MAX_TABLE_BITS) - tb_sat;
    bucket_in = in_word[KEY_W-1 -: MAX_TABLE_BITS] >> shamt;
  end

  // Query registers.
  logic [KEY_W-1:0]          key_r;
  logic [MAX_TABLE_BITS-1:0] bucket_r;
  logic [START_W-1:0]        start_r;
  logic [START_W-1:0]        size_r;
  logic [CNT_W-1:0]          stop_r;
  logic [CNT_W-1:0]          idx_r;
  logic [CNT_W-1:0]          idx_nxt;

  // Start table: the same read port serves the bucket start, then the end.
  logic               starts_we;
  logic [SADDR_W-1:0] starts_raddr;
  logic [START_W-1:0] starts_rdata;

  assign starts_we = accept && (in_opcode == OP_WR_START)
                     && (int'(in_slot) < STARTS_DEPTH);
  assign starts_raddr = ctrl.ld_start ? (SADDR_W'(bucket_r) + 1'b1)
                                      : SADDR_W'(bucket_in);

  bsh_ram #(
    .WIDTH (START_W),
    .DEPTH (STARTS_DEPTH)
  ) u_starts (
    .clk   (clk),
    .we    (starts_we),
    .waddr (SADDR_W'(in_slot)),
    .wdata (in_word[START_W-1:0]),
    .raddr (starts_raddr),
    .rdata (starts_rdata)
  );

  // Entry table: read one index ahead of the compare.
  logic             hash_we;
  logic [KEY_W-1:0] hash_rdata;

  assign hash_we = accept && (in_opcode == OP_WR_HASH) && (int'(in_slot) < ENTRIES);

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.scan_init) begin
      idx_nxt = CNT_W'(start_r);
    end else if (ctrl.scan_adv) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  bsh_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_hashes (
    .clk   (clk),
    .we    (hash_we),
    .waddr (EIDX_W'(in_slot)),
    .wdata (in_word),
    .raddr (idx_nxt[EIDX_W-1:0]),
    .rdata (hash_rdata)
  );

  // Bucket bounds, valid while the end word is on the read port.
  logic [START_W-1:0] size_cur;
  logic [CNT_W-1:0]   stop_cur;
  logic               reversed;

  always_comb begin
    reversed = starts_rdata < start_r;
    size_cur = reversed ? '0 : (starts_rdata - start_r);
    if (CNT_W'(starts_rdata) < CNT_W'(ENTRIES)) begin
      stop_cur = CNT_W'(starts_rdata);
    end else begin
      stop_cur = CNT_W'(ENTRIES);
    end
  end

  assign stat.query   = start && (in_opcode == OP_QUERY);
  assign stat.empty   = reversed || (CNT_W'(start_r) >= stop_cur);
  assign stat.hash_eq = hash_rdata == key_r;
  assign stat.hash_gt = hash_rdata > key_r;
  assign stat.last    = (idx_r + 1'b1) >= stop_r;

  bsh_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.ld_key) begin
      key_r    <= in_word;
      bucket_r <= bucket_in;
    end
    if (ctrl.ld_start) begin
      start_r <= starts_rdata;
    end
    if (ctrl.ld_end) begin
      size_r <= size_cur;
      stop_r <= stop_cur;
    end
    idx_r <= idx_nxt;
  end

  // Result register: strobe for one cycle, payload held until the next result.
  logic               out_valid_r;
  logic               out_found_r;
  logic [POS_W-1:0]   out_position_r;
  logic [START_W-1:0] out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_found_r    <= ctrl.hit;
      out_position_r <= ctrl.hit ? POS_W'(idx_r) : '0;
      out_size_r     <= ctrl.ld_end ? size_cur : size_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_bucket_size = out_size_r;

endmodule

// File: rtl/bsh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bsh_fsm.sv
// Query sequencer: start read, end read, then for a non-empty bucket one entry compare per cycle.
module bsh_fsm
  import bsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fsm_stat_t stat,
  output fsm_ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.query) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_END;
      end
      ST_END: begin
        state_nxt = stat.empty ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.hash_eq || stat.hash_gt || stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.ld_key = stat.query;
      end
      ST_START: begin
        ctrl.busy     = 1'b1;
        ctrl.ld_start = 1'b1;
      end
      ST_END: begin
        ctrl.busy      = 1'b1;
        ctrl.ld_end    = 1'b1;
        ctrl.done      = stat.empty;
        ctrl.scan_init = !stat.empty;
      end
      ST_SCAN: begin
        ctrl.busy = 1'b1;
        if (stat.hash_eq) begin
          ctrl.done = 1'b1;
          ctrl.hit  = 1'b1;
        end else if (stat.hash_gt || stat.last) begin
          ctrl.done = 1'b1;
        end else begin
          ctrl.scan_adv = 1'b1;
        end
      end
      default: begin
        ctrl.busy = 1'b1;
      end
    endcase
  end

endmodule
